>>> rtl/core/scp_pkg.sv
`default_nettype none

package scp_pkg;

  localparam int LINE_DEPTH_DEF     = 32;
  localparam int MAX_ARG_DIGITS_DEF = 5;

  // first argument byte follows the three command letters and one separator
  localparam int ARG_START = 4;
  localparam int PREFIX_LEN = 3;

  localparam logic [7:0] CHAR_TERM   = 8'h23;
  localparam logic [7:0] CHAR_NUL    = 8'h00;
  localparam logic [7:0] CHAR_P      = 8'h70;
  localparam logic [7:0] CHAR_W      = 8'h77;
  localparam logic [7:0] CHAR_M      = 8'h6d;
  localparam logic [7:0] CHAR_A      = 8'h61;
  localparam logic [7:0] CHAR_D      = 8'h64;
  localparam logic [7:0] CHAR_C      = 8'h63;
  localparam logic [7:0] CHAR_E      = 8'h65;
  localparam logic [7:0] CHAR_H      = 8'h68;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_NINE   = 8'h39;
  localparam logic [7:0] CHAR_UP_A   = 8'h41;
  localparam logic [7:0] CHAR_UP_F   = 8'h46;
  localparam logic [7:0] CHAR_LO_A   = 8'h61;
  localparam logic [7:0] CHAR_LO_F   = 8'h66;

  localparam logic [3:0] LETTER_BASE = 4'd10;

  typedef enum logic [1:0] {
    CMD_NONE = 2'd0,
    CMD_PWM  = 2'd1,
    CMD_ADC  = 2'd2,
    CMD_ECHO = 2'd3
  } cmd_t;

  typedef struct packed {
    logic       wr;
    logic       term;
    logic [7:0] data;
  } store_ctl_t;

  // argument bytes that lie inside the buffer
  function automatic int arg_slots(int depth, int digits);
    int room;
    room = depth - ARG_START;
    return (digits < room) ? digits : room;
  endfunction

  // bit 4 set when the byte is a digit, low bits its worth
  function automatic logic [4:0] digit_value(logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= CHAR_UP_A && c <= CHAR_UP_F) begin
      r = {1'b1, 4'(c - CHAR_UP_A) + LETTER_BASE};
    end else if (c >= CHAR_LO_A && c <= CHAR_LO_F) begin
      r = {1'b1, 4'(c - CHAR_LO_A) + LETTER_BASE};
    end else if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      r = {1'b1, 4'(c - CHAR_ZERO)};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/scp_line_store.sv
`default_nettype none

module scp_line_store #(
  parameter int LINE_DEPTH     = scp_pkg::LINE_DEPTH_DEF,
  parameter int MAX_ARG_DIGITS = scp_pkg::MAX_ARG_DIGITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire scp_pkg::store_ctl_t    ctl_i,
  output logic [scp_pkg::PREFIX_LEN-1:0][7:0] prefix_o,
  output logic [scp_pkg::arg_slots(LINE_DEPTH, MAX_ARG_DIGITS)-1:0][7:0] arg_o
);

  localparam int ARG_SLOTS = scp_pkg::arg_slots(LINE_DEPTH, MAX_ARG_DIGITS);
  localparam int PW        = $clog2(LINE_DEPTH);
  localparam logic [PW-1:0] LAST_POS = PW'(LINE_DEPTH - 1);

  // only the bytes that decoding looks at are kept
  logic [scp_pkg::PREFIX_LEN-1:0][7:0] prefix_r;
  logic [ARG_SLOTS-1:0][7:0]           arg_r;
  logic [PW-1:0]                       wp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prefix_r <= '0;
      arg_r    <= '0;
      wp_r     <= '0;
    end else if (ctl_i.term) begin
      prefix_r <= '0;
      arg_r    <= '0;
      wp_r     <= '0;
    end else if (ctl_i.wr) begin
      for (int i = 0; i < scp_pkg::PREFIX_LEN; i++) begin
        if (wp_r == PW'(i)) prefix_r[i] <= ctl_i.data;
      end
      for (int i = 0; i < ARG_SLOTS; i++) begin
        if (wp_r == PW'(scp_pkg::ARG_START + i)) arg_r[i] <= ctl_i.data;
      end
      wp_r <= (wp_r == LAST_POS) ? '0 : wp_r + 1'b1;
    end
  end

  // the terminator's zero lands at the write position
  always_comb begin
    for (int i = 0; i < scp_pkg::PREFIX_LEN; i++) begin
      prefix_o[i] = (ctl_i.term && wp_r == PW'(i)) ? scp_pkg::CHAR_NUL : prefix_r[i];
    end
    for (int i = 0; i < ARG_SLOTS; i++) begin
      arg_o[i] = (ctl_i.term && wp_r == PW'(scp_pkg::ARG_START + i)) ?
                 scp_pkg::CHAR_NUL : arg_r[i];
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/scp_decode.sv
`default_nettype none

module scp_decode #(
  parameter int LINE_DEPTH     = scp_pkg::LINE_DEPTH_DEF,
  parameter int MAX_ARG_DIGITS = scp_pkg::MAX_ARG_DIGITS_DEF
) (
  input  wire logic [scp_pkg::PREFIX_LEN-1:0][7:0] prefix_i,
  input  wire logic [scp_pkg::arg_slots(LINE_DEPTH, MAX_ARG_DIGITS)-1:0][7:0] arg_i,
  input  wire logic                                radix_hex_i,
  output scp_pkg::cmd_t                            cmd_o,
  output logic [15:0]                              value_o
);

  localparam int ARG_SLOTS = scp_pkg::arg_slots(LINE_DEPTH, MAX_ARG_DIGITS);

  logic [15:0] acc;
  logic        run;
  logic [4:0]  dv;

  // digit scan stops at the first byte that is not a digit (a zero included)
  always_comb begin
    acc = '0;
    run = 1'b1;
    dv  = '0;
    for (int i = 0; i < ARG_SLOTS; i++) begin
      dv = scp_pkg::digit_value(arg_i[i]);
      if (run && dv[4]) begin
        if (radix_hex_i) acc = {acc[11:0], 4'd0} + {12'd0, dv[3:0]};
        else             acc = {acc[12:0], 3'd0} + {acc[14:0], 1'b0} + {12'd0, dv[3:0]};
      end else begin
        run = 1'b0;
      end
    end
  end

  always_comb begin
    cmd_o   = scp_pkg::CMD_NONE;
    value_o = '0;
    if (prefix_i[0] == scp_pkg::CHAR_P && prefix_i[1] == scp_pkg::CHAR_W &&
        prefix_i[2] == scp_pkg::CHAR_M) begin
      cmd_o   = scp_pkg::CMD_PWM;
      value_o = acc;
    end else if (prefix_i[0] == scp_pkg::CHAR_A && prefix_i[1] == scp_pkg::CHAR_D &&
                 prefix_i[2] == scp_pkg::CHAR_C) begin
      cmd_o = scp_pkg::CMD_ADC;
    end else if (prefix_i[0] == scp_pkg::CHAR_E && prefix_i[1] == scp_pkg::CHAR_C &&
                 prefix_i[2] == scp_pkg::CHAR_H) begin
      cmd_o = scp_pkg::CMD_ECHO;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/serial_command_line_parser_unit.sv
// result: a terminator beat goes from the input register into the result register, and
// waits in the input register while a pending result is not taken; throughput: one byte
// per cycle but for such a wait; bytes other than the terminator never wait
// reset (rst_n low, synchronous): line buffer cleared, write position 0, radix decimal,
// both registers empty; no clearing pass follows
`default_nettype none

module serial_command_line_parser_unit #(
  parameter int LINE_DEPTH     = scp_pkg::LINE_DEPTH_DEF,
  parameter int MAX_ARG_DIGITS = scp_pkg::MAX_ARG_DIGITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic        cfg_wr_data,   // radix_hex
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,      // [7:0] rx_byte
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata      // [1:0] command, [17:2] argument value, rest zero
);

  localparam int ARG_SLOTS = scp_pkg::arg_slots(LINE_DEPTH, MAX_ARG_DIGITS);

  logic        radix_r;
  logic        in_valid_r;
  logic [7:0]  in_byte_r;
  logic        out_valid_r;
  logic [1:0]  out_cmd_r;
  logic [15:0] out_value_r;

  logic        is_term;
  logic        can_out;
  logic        advance;

  scp_pkg::store_ctl_t                 ctl;
  logic [scp_pkg::PREFIX_LEN-1:0][7:0] prefix;
  logic [ARG_SLOTS-1:0][7:0]           args;
  scp_pkg::cmd_t                       cmd;
  logic [15:0]                         value;

  assign is_term   = in_byte_r == scp_pkg::CHAR_TERM;
  assign can_out   = !out_valid_r || out_tready;
  assign advance   = in_valid_r && (!is_term || can_out);
  assign in_tready = !in_valid_r || advance;

  assign ctl.wr   = advance && !is_term;
  assign ctl.term = advance && is_term;
  assign ctl.data = in_byte_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= 1'b0;
    end else if (cfg_wr_en) begin
      radix_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) in_byte_r <= in_tdata;
  end

  scp_line_store #(
    .LINE_DEPTH     (LINE_DEPTH),
    .MAX_ARG_DIGITS (MAX_ARG_DIGITS)
  ) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl_i    (ctl),
    .prefix_o (prefix),
    .arg_o    (args)
  );

  scp_decode #(
    .LINE_DEPTH     (LINE_DEPTH),
    .MAX_ARG_DIGITS (MAX_ARG_DIGITS)
  ) u_decode (
    .prefix_i    (prefix),
    .arg_i       (args),
    .radix_hex_i (radix_r),
    .cmd_o       (cmd),
    .value_o     (value)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.term) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.term) begin
      out_cmd_r   <= cmd;
      out_value_r <= value;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_value_r, out_cmd_r};

  // a byte other than the terminator never stalls in the input register
  a_plain_byte_flows: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !is_term |-> advance)
    else $error("plain byte held in input register");

  // a result appears only after a terminator has left the input register
  a_result_from_term: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(in_valid_r && is_term))
    else $error("result without terminator");

  // the argument is reported for a pwm line only
  a_value_only_pwm: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_cmd_r != scp_pkg::CMD_PWM |-> out_value_r == 16'd0)
    else $error("argument on a non-pwm result");

  // a pending result is never overwritten before it is taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |-> !ctl.term)
    else $error("result overwritten while stalled");

endmodule

`default_nettype wire
